[sv/sorted_key_table_top_macros.svh]
// Assertion macros for the sorted key table.
// Used by sorted_key_table_top; expects clk_i and rst_ni in scope.
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// Condition and consequence in the same cycle.
`define STK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Consequence in the cycle after the condition.
`define STK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[sv/stk_pkg.sv]
// Shared constants and types of the sorted key table.
// No dependencies; used by stk_cell and sorted_key_table_top.
package stk_pkg;

  // Default configuration.
  localparam int unsigned CapacityDef    = 64;
  localparam int unsigned KeyBitsDef     = 32;
  localparam int unsigned PayloadBitsDef = 16;

  // Fixed result field widths.
  localparam int unsigned PosW = 6;
  localparam int unsigned CntW = 7;

  // Action codes.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic ins_en;
    logic rm_en;
  } stk_cmd_t;

  // Compare flags handed from a cell to its right neighbour.
  typedef struct packed {
    logic vld;
    logic gt;
    logic eq;
  } stk_flags_t;

endpackage

[sv/stk_cell.sv]
// One entry of the sorted key table: key and payload registers, compare
// against the current item and shift from either neighbour. Uses stk_pkg.
module stk_cell
  import stk_pkg::*;
#(
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                    clk_i,
  input  stk_cmd_t                cmd_i,
  input  logic                    vld_i,
  input  stk_flags_t              left_i,
  input  logic [KEY_BITS-1:0]     item_key_i,
  input  logic [PAYLOAD_BITS-1:0] item_pay_i,
  input  logic [KEY_BITS-1:0]     left_key_i,
  input  logic [PAYLOAD_BITS-1:0] left_pay_i,
  input  logic [KEY_BITS-1:0]     right_key_i,
  input  logic [PAYLOAD_BITS-1:0] right_pay_i,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0] pay_o,
  output stk_flags_t              flags_o,
  output logic                    first_o,
  output logic                    ins_o,
  output logic [PAYLOAD_BITS-1:0] sel_pay_o
);

  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    gt, eq;

  // Compare the stored key with the item key; empty cells never match.
  assign gt = vld_i && (key_q > item_key_i);
  assign eq = vld_i && (key_q == item_key_i);

  // Equal keys are contiguous, so the first match is an equal cell whose
  // left neighbour is not equal.
  assign first_o = eq && !left_i.eq;

  // The insertion point is the first greater cell, or the first empty cell
  // when no stored key is greater.
  assign ins_o = !left_i.gt && (gt || (!vld_i && left_i.vld));

  assign flags_o   = '{vld: vld_i, gt: gt, eq: eq};
  assign sel_pay_o = first_o ? pay_q : '0;
  assign key_o     = key_q;
  assign pay_o     = pay_q;

  // Next contents: shift up on insert, shift down from the match on remove.
  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (cmd_i.ins_en) begin
      if (left_i.gt) begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end else if (ins_o) begin
        key_d = item_key_i;
        pay_d = item_pay_i;
      end
    end else if (cmd_i.rm_en && (eq || gt)) begin
      key_d = right_key_i;
      pay_d = right_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

endmodule

[sv/sorted_key_table_top.sv]
// Sorted key table: a row of CAPACITY cells kept in ascending key order.
// Channels: an input channel (in_valid_i / in_ready_o) carries one
// transaction with action, key and payload; an output channel
// (out_valid_o / out_ready_i) returns status, position, found payload and
// the entry count after the operation. Every input transaction gives
// exactly one result.
// Operation: the item is registered on acceptance; once the output register
// is free, every cell compares its key against the held item and shifts in
// parallel while the result is written into the output register.
// Throughput: one transaction per cycle while the receiver is ready; a new
// item is taken in the same cycle that the held item commits, so with the
// receiver ready an item completes each cycle after its acceptance cycle.
// The commit of the held item is set by the output register being free.
// Reset clears the entry count and both valid flags; the cell contents are
// undefined and are never read before being written.
// If the receiver stalls, the held item waits until the output register is
// free, and the input channel accepts nothing more in the meantime.
// Depends on stk_pkg, stk_cell and sorted_key_table_top_macros.svh.
`include "sorted_key_table_top_macros.svh"

module sorted_key_table_top
  import stk_pkg::*;
#(
  parameter int unsigned CAPACITY     = CapacityDef,
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [PosW-1:0]         position_o,
  output logic [PAYLOAD_BITS-1:0] found_payload_o,
  output logic [CntW-1:0]         entry_count_o
);

  localparam int unsigned IdxBits = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntBits = $clog2(CAPACITY + 1);

  // Held item and control state.
  logic                    busy_q, busy_d;
  logic [1:0]              act_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [CntBits-1:0]      count_q, count_d;
  logic                    accept, commit, full, found;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              status_q, status_d;
  logic [PosW-1:0]         position_q, position_d;
  logic [PAYLOAD_BITS-1:0] fpay_q, fpay_d;
  logic [CntW-1:0]         ecount_q, ecount_d;

  // Cell row signals.
  stk_cmd_t                cmd;
  logic [CAPACITY-1:0]     cell_vld, first_vec, ins_vec;
  stk_flags_t              flags [CAPACITY];
  logic [KEY_BITS-1:0]     cell_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay [CAPACITY];
  logic [PAYLOAD_BITS-1:0] sel_pay [CAPACITY];
  logic [IdxBits-1:0]      match_pos, ins_pos;
  logic [PAYLOAD_BITS-1:0] match_pay;

  // Handshake: the held item commits once the output register is free.
  assign commit     = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || commit;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntBits'(CAPACITY));
  assign found      = |first_vec;

  assign cmd.ins_en = commit && (act_q == ACT_INSERT) && !full;
  assign cmd.rm_en  = commit && (act_q == ACT_REMOVE) && found;

  // Row of cells, each linked to its neighbours.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    stk_flags_t              left_flags;
    logic [KEY_BITS-1:0]     left_key, right_key;
    logic [PAYLOAD_BITS-1:0] left_pay, right_pay;

    assign cell_vld[i] = (count_q > CntBits'(i));

    if (i == 0) begin : g_first
      assign left_flags = '{vld: 1'b1, gt: 1'b0, eq: 1'b0};
      assign left_key   = '0;
      assign left_pay   = '0;
    end else begin : g_mid
      assign left_flags = flags[i-1];
      assign left_key   = cell_key[i-1];
      assign left_pay   = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
      assign right_pay = cell_pay[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
      assign right_pay = cell_pay[i+1];
    end

    stk_cell #(
      .KEY_BITS    (KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .vld_i      (cell_vld[i]),
      .left_i     (left_flags),
      .item_key_i (key_q),
      .item_pay_i (pay_q),
      .left_key_i (left_key),
      .left_pay_i (left_pay),
      .right_key_i(right_key),
      .right_pay_i(right_pay),
      .key_o      (cell_key[i]),
      .pay_o      (cell_pay[i]),
      .flags_o    (flags[i]),
      .first_o    (first_vec[i]),
      .ins_o      (ins_vec[i]),
      .sel_pay_o  (sel_pay[i])
    );
  end

  // Encode the one-hot match and insertion points and gather the payload.
  always_comb begin
    match_pos = '0;
    ins_pos   = '0;
    match_pay = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) begin
        match_pos = match_pos | IdxBits'(i);
      end
      if (ins_vec[i]) begin
        ins_pos = ins_pos | IdxBits'(i);
      end
      match_pay = match_pay | sel_pay[i];
    end
  end

  // Result and entry count for the held item.
  always_comb begin
    count_d    = count_q;
    status_d   = status_q;
    position_d = position_q;
    fpay_d     = fpay_q;
    ecount_d   = ecount_q;
    if (commit) begin
      status_d   = ST_NOT_FOUND;
      position_d = '0;
      fpay_d     = '0;
      case (act_q)
        ACT_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d   = ST_OK;
            position_d = PosW'(ins_pos);
            count_d    = count_q + CntBits'(1);
          end
        end
        ACT_SEARCH: begin
          if (found) begin
            status_d   = ST_OK;
            position_d = PosW'(match_pos);
            fpay_d     = match_pay;
          end
        end
        ACT_REMOVE: begin
          if (found) begin
            status_d   = ST_OK;
            position_d = PosW'(match_pos);
            fpay_d     = match_pay;
            count_d    = count_q - CntBits'(1);
          end
        end
        default: begin
          status_d = ST_NOT_FOUND;
        end
      endcase
      ecount_d = CntW'(count_d);
    end
  end

  assign busy_d      = accept || (busy_q && !commit);
  assign out_valid_d = commit || (out_valid_q && !out_ready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Held item and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      key_q <= key_i;
      pay_q <= payload_i;
    end
    status_q   <= status_d;
    position_q <= position_d;
    fpay_q     <= fpay_d;
    ecount_q   <= ecount_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign position_o      = position_q;
  assign found_payload_o = fpay_q;
  assign entry_count_o   = ecount_q;

  // Checks on the cell row and the entry count.
  `STK_ASSERT_SAME(a_count_in_range, 1'b1, count_q <= CntBits'(CAPACITY), "count above capacity")
  `STK_ASSERT_SAME(a_single_match, 1'b1, $onehot0(first_vec), "several match points")
  `STK_ASSERT_SAME(a_single_ins, 1'b1, $onehot0(ins_vec), "several insertion points")
  `STK_ASSERT_NEXT(a_ins_grows, cmd.ins_en, count_q == $past(count_q) + CntBits'(1), "no growth")
  `STK_ASSERT_NEXT(a_rm_shrinks, cmd.rm_en, count_q == $past(count_q) - CntBits'(1), "no shrink")

endmodule
